/* rtl/core/fwm_pkg.sv */
// fwm_pkg: widths and link types shared by the fee window minimum core
// and its cells. Depends on nothing.
`default_nettype none

package fwm_pkg;

    localparam int FEE_W  = 51;
    localparam int SIZE_W = 5;

    // one pair of fee amounts
    typedef struct packed {
        logic [FEE_W-1:0] fwd;
        logic [FEE_W-1:0] req;
    } fee_pair_t;

    // what a cell hands to its older neighbour on a shift
    typedef struct packed {
        logic      valid;
        fee_pair_t fees;
    } cell_link_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } fwm_state_t;

endpackage

`default_nettype wire

/* rtl/core/fwm_cell.sv */
// fwm_cell: one slot of the fee window, holding one pair and a running
// minimum that ripples to the next cell. Depends on fwm_pkg.
`default_nettype none

module fwm_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift,
    input  wire logic               keep,
    input  wire fwm_pkg::cell_link_t prev,
    input  wire fwm_pkg::fee_pair_t  prev_min,
    output fwm_pkg::cell_link_t      own,
    output fwm_pkg::fee_pair_t       min_out
);
    import fwm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    fee_pair_t fees_reg;
    fee_pair_t fees_next;
    fee_pair_t min_reg;
    fee_pair_t min_next;

    // shift in from the newer neighbour, drop the slot past the window limit
    always_comb
    begin
        valid_next = valid_reg;
        fees_next  = fees_reg;
        if (shift)
        begin
            valid_next = prev.valid & keep;
            fees_next  = prev.fees;
        end
    end

    // running minimum: own pair against what the newer side has seen
    always_comb
    begin
        min_next = prev_min;
        if (valid_reg)
        begin
            if (fees_reg.fwd < prev_min.fwd)
            begin
                min_next.fwd = fees_reg.fwd;
            end
            if (fees_reg.req < prev_min.req)
            begin
                min_next.req = fees_reg.req;
            end
        end
    end

    // slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slot payload and running minimum
    always_ff @(posedge clk)
    begin
        fees_reg <= fees_next;
        min_reg  <= min_next;
    end

    assign own.valid = valid_reg;
    assign own.fees  = fees_reg;
    assign min_out   = min_reg;

endmodule

`default_nettype wire

/* rtl/core/fee_window_minimum_core.sv */
// fee_window_minimum_core: sliding-window minimum of fee pairs built as a
// shift chain of fwm_cell slots with a rippling minimum.
// Depends on fwm_pkg and fwm_cell.
//
//   channel   direction  handshake               payload
//   in        into core  in_valid / in_ready     forward_fee, request_fee
//   out       from core  out_valid / out_ready   min_forward_fee, min_request_fee,
//                                                pairs_held
//   cfg       into core  cfg_valid / cfg_ready   window_size
//
// An accepted request shifts into the chain, then the minimum ripples one
// cell per cycle down the DEPTH cells; no new request is taken until the
// sweep has finished and the sequencer is back in idle.
// The result sits in an output register; a stalled output holds the sweep
// at its last step until the register frees. Reset empties the window at
// once through the cell valid bits and sets window_size to one.
`default_nettype none

module fee_window_minimum_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [fwm_pkg::FEE_W-1:0]  forward_fee,
    input  wire logic [fwm_pkg::FEE_W-1:0]  request_fee,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [fwm_pkg::FEE_W-1:0]       min_forward_fee,
    output logic [fwm_pkg::FEE_W-1:0]       min_request_fee,
    output logic [fwm_pkg::SIZE_W-1:0]      pairs_held,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fwm_pkg::SIZE_W-1:0] window_size
);
    import fwm_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] LIM_CAP = SIZE_W'((DEPTH > SIZE_MAX) ? SIZE_MAX : DEPTH);
    localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(DEPTH);

    fwm_state_t          state_reg;
    fwm_state_t          state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [SIZE_W-1:0]   win_reg;
    logic [SIZE_W-1:0]   held_reg;
    logic [SIZE_W-1:0]   held_next;
    logic [SIZE_W-1:0]   lim;
    logic                out_valid_reg;
    logic                out_valid_next;
    fee_pair_t           res_reg;
    logic [SIZE_W-1:0]   res_held_reg;
    logic                in_take;
    logic                out_free;
    logic                done;

    cell_link_t          link [DEPTH+1];
    fee_pair_t           mins [DEPTH+1];
    logic [DEPTH-1:0]    keep;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign done      = (state_reg == ST_SWEEP) && (cnt_reg == SWEEP_LAST) && out_free;

    // effective window limit: zero reads as one, large values saturate
    always_comb
    begin
        lim = win_reg;
        if (win_reg == '0)
        begin
            lim = SIZE_W'(1);
        end
        else if (win_reg > LIM_CAP)
        begin
            lim = LIM_CAP;
        end
    end

    // new pair enters at the head of the chain; constant ceiling starts the minimum
    assign link[0].valid    = 1'b1;
    assign link[0].fees.fwd = forward_fee;
    assign link[0].fees.req = request_fee;
    assign mins[0].fwd      = '1;
    assign mins[0].req      = '1;

    // chain of slots, newest at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign keep[i] = (32'(lim) > i);

        fwm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (in_take),
            .keep     (keep[i]),
            .prev     (link[i]),
            .prev_min (mins[i]),
            .own      (link[i+1]),
            .min_out  (mins[i+1])
        );
    end

    // sequencer and pair count
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SWEEP;
                    cnt_next   = '0;
                    held_next  = (held_reg >= lim) ? lim : held_reg + SIZE_W'(1);
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg != SWEEP_LAST)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            held_reg      <= '0;
            win_reg       <= SIZE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                win_reg <= window_size;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg      <= mins[DEPTH];
            res_held_reg <= held_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign min_forward_fee = res_reg.fwd;
    assign min_request_fee = res_reg.req;
    assign pairs_held      = res_held_reg;

endmodule

`default_nettype wire

/* rtl/core/fwm_checker.sv */
// fwm_port_checks: port-level checks for fee_window_minimum_core, bound to
// every instance of it by the bind below. Depends on fwm_pkg.
`default_nettype none

module fwm_port_checks (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [fwm_pkg::FEE_W-1:0]  min_forward_fee,
    input wire logic [fwm_pkg::FEE_W-1:0]  min_request_fee,
    input wire logic [fwm_pkg::SIZE_W-1:0] pairs_held,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready,
    input wire logic [fwm_pkg::SIZE_W-1:0] window_size
);
    import fwm_pkg::*;

    logic [SIZE_W-1:0] win_seen_reg;

    // window setting as last written on the register channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_seen_reg <= SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            win_seen_reg <= window_size;
        end
    end

    // the core is busy sweeping right after taking a request
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high in the cycle after a request was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_forward_fee)
            && $stable(min_request_fee) && $stable(pairs_held))
        else $error("result changed while stalled");

    // every result covers at least the new pair
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pairs_held != '0)
        else $error("result with an empty window");

    // never more pairs than the window allows
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pairs_held <= win_seen_reg) || (pairs_held == SIZE_W'(1)))
        else $error("pair count exceeds window size");

endmodule

bind fee_window_minimum_core fwm_port_checks u_fwm_port_checks (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .min_forward_fee (min_forward_fee),
    .min_request_fee (min_request_fee),
    .pairs_held      (pairs_held),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .window_size     (window_size)
);

`default_nettype wire

/* sim/fwm_checker.sv */
// fwm_checker: watches the request, result and register channels of the fee
// window minimum core, predicts every result and compares it field by field.
// Depends on fwm_pkg.
module fwm_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [fwm_pkg::FEE_W-1:0]  forward_fee,
    input  wire logic [fwm_pkg::FEE_W-1:0]  request_fee,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [fwm_pkg::FEE_W-1:0]  min_forward_fee,
    input  wire logic [fwm_pkg::FEE_W-1:0]  min_request_fee,
    input  wire logic [fwm_pkg::SIZE_W-1:0] pairs_held,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [fwm_pkg::SIZE_W-1:0] window_size,
    input  wire logic                       wrap_up,
    output int                              awaiting,
    output int                              fail_count,
    output int                              checked_count
);

    import fwm_pkg::*;

    localparam int DUE_SLOTS = 64;

    typedef struct packed {
        logic [FEE_W-1:0]  min_fwd;
        logic [FEE_W-1:0]  min_req;
        logic [SIZE_W-1:0] held;
    } fee_minima_t;

    fee_minima_t       minima_due [DUE_SLOTS];
    int unsigned       due_head;
    int unsigned       due_tail;
    int unsigned       due_count;
    logic [FEE_W-1:0]  fwd_window [DEPTH];
    logic [FEE_W-1:0]  req_window [DEPTH];
    int unsigned       held_pairs;
    logic [SIZE_W-1:0] size_setting;
    int                fail_tally;
    int                checked_tally;
    bit                leftover_counted;

    // trim the window to the setting, append the new pair, take both minima
    task automatic push_and_minimise(input logic [FEE_W-1:0] fwd,
                                     input logic [FEE_W-1:0] req,
                                     output fee_minima_t res);
        int unsigned limit;
        int unsigned keep;
        int unsigned drop;
        limit = (size_setting == '0) ? 1 :
                ((size_setting > DEPTH) ? DEPTH : int'(size_setting));
        keep = limit - 1;
        if (held_pairs > keep)
        begin
            drop = held_pairs - keep;
            for (int i = 0; i < keep; i++)
            begin
                fwd_window[i] = fwd_window[i + drop];
                req_window[i] = req_window[i + drop];
            end
            held_pairs = keep;
        end
        fwd_window[held_pairs] = fwd;
        req_window[held_pairs] = req;
        held_pairs++;
        res.min_fwd = fwd_window[0];
        res.min_req = req_window[0];
        for (int i = 1; i < held_pairs; i++)
        begin
            if (fwd_window[i] < res.min_fwd)
                res.min_fwd = fwd_window[i];
            if (req_window[i] < res.min_req)
                res.min_req = req_window[i];
        end
        res.held = held_pairs[SIZE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fee_minima_t due;
        fee_minima_t fresh;
        if (!rst_n)
        begin
            due_head  = 0;
            due_tail  = 0;
            due_count = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                fwd_window[i] = '0;
                req_window[i] = '0;
            end
            held_pairs       = 0;
            size_setting     = 5'd1;
            fail_tally       = 0;
            checked_tally    = 0;
            leftover_counted = 1'b0;
        end
        else
        begin
            // results first: a result never belongs to a request taken this edge
            if (out_valid && out_ready)
            begin
                if (due_count == 0)
                begin
                    $display("%0t unexpected result: min_forward_fee %0d", $time,
                             min_forward_fee);
                    $display("%0t   min_request_fee %0d pairs_held %0d", $time,
                             min_request_fee, pairs_held);
                    fail_tally++;
                end
                else
                begin
                    due       = minima_due[due_head];
                    due_head  = (due_head + 1) % DUE_SLOTS;
                    due_count = due_count - 1;
                    checked_tally++;
                    if (min_forward_fee !== due.min_fwd)
                    begin
                        $display("%0t min_forward_fee mismatch: expected %0d actual %0d",
                                 $time, due.min_fwd, min_forward_fee);
                        fail_tally++;
                    end
                    if (min_request_fee !== due.min_req)
                    begin
                        $display("%0t min_request_fee mismatch: expected %0d actual %0d",
                                 $time, due.min_req, min_request_fee);
                        fail_tally++;
                    end
                    if (pairs_held !== due.held)
                    begin
                        $display("%0t pairs_held mismatch: expected %0d actual %0d",
                                 $time, due.held, pairs_held);
                        fail_tally++;
                    end
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
                size_setting = window_size;
            // accepted request
            if (in_valid && in_ready)
            begin
                push_and_minimise(forward_fee, request_fee, fresh);
                if (due_count == DUE_SLOTS)
                begin
                    $display("%0t too many results outstanding", $time);
                    fail_tally++;
                end
                else
                begin
                    minima_due[due_tail] = fresh;
                    due_tail  = (due_tail + 1) % DUE_SLOTS;
                    due_count = due_count + 1;
                end
            end
            // anything still owed at the end is a failure
            if (wrap_up && !leftover_counted)
            begin
                leftover_counted = 1'b1;
                if (due_count != 0)
                begin
                    $display("%0t %0d results never arrived", $time, due_count);
                    fail_tally += int'(due_count);
                end
            end
        end
        awaiting      <= int'(due_count);
        fail_count    <= fail_tally;
        checked_count <= checked_tally;
    end

endmodule

/* sim/testbench.sv */
// testbench: drives requests, register writes and result back-pressure into
// fee_window_minimum_core and gives the verdict from fwm_checker.
// Depends on fwm_pkg, fee_window_minimum_core and fwm_checker.
module testbench;

    import fwm_pkg::*;

    localparam int DEPTH        = 16;
    localparam int TARGET_PAIRS = 1750;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_WAIT  = DEPTH + 4;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [FEE_W-1:0] MONEY_MAX    = 51'd2100000000000000;
    localparam logic [FEE_W-1:0] FEE_ALL_ONES = 51'h7_FFFF_FFFF_FFFF;
    localparam logic [FEE_W-1:0] FEE_ALT_A    = 51'h2_AAAA_AAAA_AAAA;
    localparam logic [FEE_W-1:0] FEE_ALT_B    = 51'h5_5555_5555_5555;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [FEE_W-1:0]  forward_fee;
    logic [FEE_W-1:0]  request_fee;
    logic              out_valid;
    logic              out_ready;
    logic [FEE_W-1:0]  min_forward_fee;
    logic [FEE_W-1:0]  min_request_fee;
    logic [SIZE_W-1:0] pairs_held;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] window_size;
    logic              wrap_up;

    int awaiting;
    int fail_count;
    int checked_count;
    int cycle_count;
    int pairs_sent;
    int writes_done;
    bit sender_calm;
    bit hold_request;

    fee_window_minimum_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .forward_fee     (forward_fee),
        .request_fee     (request_fee),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .min_forward_fee (min_forward_fee),
        .min_request_fee (min_request_fee),
        .pairs_held      (pairs_held),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .window_size     (window_size)
    );

    fwm_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .forward_fee     (forward_fee),
        .request_fee     (request_fee),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .min_forward_fee (min_forward_fee),
        .min_request_fee (min_request_fee),
        .pairs_held      (pairs_held),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .window_size     (window_size),
        .wrap_up         (wrap_up),
        .awaiting        (awaiting),
        .fail_count      (fail_count),
        .checked_count   (checked_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t watchdog expired with %0d results outstanding", $time, awaiting);
        $display("Test completed with failures");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 45);
    endfunction

    // fee amount: extremes, small values that tie and nest, full-width noise
    function automatic logic [FEE_W-1:0] draw_fee();
        logic [63:0] raw;
        logic [63:0] pick;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       pick = '0;
            1:       pick = {13'd0, FEE_ALL_ONES};
            2:       pick = {13'd0, MONEY_MAX};
            3, 4:    pick = raw % 64'd1000;
            5, 6:    pick = raw % ({13'd0, MONEY_MAX} + 64'd1);
            default: pick = raw;
        endcase
        return pick[FEE_W-1:0];
    endfunction

    // window setting per phase: extremes first, then mostly in range
    function automatic logic [SIZE_W-1:0] pick_setting(input int phase);
        logic [31:0] roll;
        case (phase)
            1:       roll = 31;
            2:       roll = 1;
            3:       roll = 16;
            4:       roll = 0;
            5:       roll = 17;
            6:       roll = 2;
            default: roll = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                      : $urandom_range(0, 31);
        endcase
        return roll[SIZE_W-1:0];
    endfunction

    // offer one request and hold it until taken
    task automatic send_pair(input logic [FEE_W-1:0] fwd, input logic [FEE_W-1:0] req);
        int gap;
        in_valid    <= 1'b1;
        forward_fee <= fwd;
        request_fee <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pairs_sent++;
        gap = sender_calm ? 0 : draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // register write once the core has gone quiet
    task automatic write_window(input logic [SIZE_W-1:0] setting);
        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_valid   <= 1'b1;
        window_size <= setting;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    // result side back-pressure, including one long hold-off
    initial
    begin : receiver
        int stall;
        int calm_left;
        bit long_hold_done;
        calm_left      = 0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                calm_left = $urandom_range(30, 150);
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = draw_gap();
                if (stall == 0)
                begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int phase;
        int phase_len;
        int pause_at;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        forward_fee  <= '0;
        request_fee  <= '0;
        cfg_valid    <= 1'b0;
        window_size  <= '0;
        wrap_up      <= 1'b0;
        pairs_sent   = 0;
        writes_done  = 0;
        sender_calm  = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one straight after reset, extremes of both fees
        send_pair('0, '0);
        send_pair(FEE_ALL_ONES, FEE_ALL_ONES);
        send_pair(MONEY_MAX, '0);

        // full window: fees above the money range, alternating bits, ties
        write_window(5'd16);
        send_pair(FEE_ALL_ONES, '0);
        send_pair(MONEY_MAX, 51'd1);
        send_pair(FEE_ALT_A, FEE_ALT_B);
        send_pair(FEE_ALT_B, FEE_ALT_A);
        send_pair(51'd7, 51'd7);
        send_pair(51'd7, 51'd3);
        send_pair(51'd100, 51'd2);
        send_pair('0, FEE_ALL_ONES);
        send_pair(51'd5, 51'd5);

        // shrunk while idle: the next request trims the window
        write_window(5'd3);
        send_pair(51'd9, 51'd9);
        send_pair(51'd8, 51'd10);

        // size zero behaves as one
        write_window(5'd0);
        send_pair(51'd40, 51'd50);
        send_pair(51'd60, 51'd30);

        // size beyond the store saturates
        write_window(5'd17);
        send_pair(51'd11, 51'd12);
        send_pair(51'd13, 51'd1);
        send_pair(51'd2, 51'd14);

        // random phases, each under its own window setting
        phase = 0;
        while (pairs_sent < TARGET_PAIRS)
        begin
            phase++;
            write_window(pick_setting(phase));
            phase_len   = $urandom_range(15, 90);
            sender_calm = ($urandom_range(0, 3) == 0);
            pause_at    = ($urandom_range(0, 9) == 0 || phase == 5) ? phase_len / 2 : -1;
            if (phase == 3)
            begin
                // back-to-back requests against a long result hold-off
                hold_request = 1'b1;
                sender_calm  = 1'b1;
                phase_len    = 40;
            end
            for (int k = 0; k < phase_len; k++)
            begin
                if (k == pause_at)
                    drain();
                send_pair(draw_fee(), draw_fee());
            end
        end
        sender_calm = 1'b0;

        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d fee pairs under %0d window writes (sizes 0 to 31),", pairs_sent,
                 writes_done);
        $display("with %0d results checked under random stalls and one long hold-off",
                 checked_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* fee_window_minimum_core.f */
rtl/core/fwm_pkg.sv
rtl/core/fwm_cell.sv
rtl/core/fee_window_minimum_core.sv
rtl/core/fwm_checker.sv
sim/fwm_checker.sv
sim/testbench.sv
